// ===== src/rbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants for the RDS bi-phase symbol shaper.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int unsigned SAMPLES_PER_SYMBOL_DEF = 160;
  localparam int unsigned PULSE_LEN_DEF          = 640;
  localparam int unsigned RING_LEN_DEF           = 800;

  localparam int unsigned SHIFT_DEPTH  = 160;
  localparam int unsigned SH_AW        = 8;
  localparam int unsigned DELAY_W      = 8;
  localparam int unsigned COEF_INDEX_W = 10;
  localparam int unsigned COEF_W       = 16;
  localparam int unsigned SAMPLE_W     = 18;
  localparam int unsigned IN_TDATA_W   = 32;
  localparam int unsigned OUT_TDATA_W  = 24;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef struct packed {
    logic clr_wr;
    logic load_wr;
    logic tick_acc;
    logic acc_issue;
    logic ring_rd;
    logic ring_clr;
    logic sh_wr;
    logic sh_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic phase_zero;
    logic acc_last;
    logic len_zero;
    logic out_free;
  } sts_t;

endpackage

// ===== src/rbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbs_ctrl
// Sequencer: clearing pass, item intake, pulse overlap-add sweep, ring read,
// delay line access and result hand-off.
// ----------------------------------------------------------------------------
module rbs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_opcode_i,
  output logic          in_ready_o,
  input  rbs_pkg::sts_t sts_i,
  output rbs_pkg::cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_ACC      = 9'b000000100,
    S_ACC_END  = 9'b000001000,
    S_RING_RD  = 9'b000010000,
    S_RING_CLR = 9'b000100000,
    S_SH_WR    = 9'b001000000,
    S_SH_RD    = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_opcode_i == rbs_pkg::OP_LOAD) begin
            cmd_o.load_wr = 1'b1;
          end else begin
            cmd_o.tick_acc = 1'b1;
            state_d = sts_i.phase_zero ? S_ACC : S_RING_RD;
          end
        end
      end
      S_ACC: begin
        cmd_o.acc_issue = 1'b1;
        if (sts_i.acc_last) begin
          state_d = S_ACC_END;
        end
      end
      S_ACC_END: begin
        state_d = S_RING_RD;
      end
      S_RING_RD: begin
        cmd_o.ring_rd = 1'b1;
        state_d = S_RING_CLR;
      end
      S_RING_CLR: begin
        cmd_o.ring_clr = 1'b1;
        state_d = sts_i.len_zero ? S_OUT : S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.sh_wr = 1'b1;
        state_d = S_SH_RD;
      end
      S_SH_RD: begin
        cmd_o.sh_rd = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/rbs_datapath.sv =====
// ----------------------------------------------------------------------------
// rbs_datapath
// Pulse table, overlap-add ring, symbol delay line, pointers and the output
// register.
// ----------------------------------------------------------------------------
module rbs_datapath #(
  parameter int unsigned SAMPLES_PER_SYMBOL = rbs_pkg::SAMPLES_PER_SYMBOL_DEF,
  parameter int unsigned PULSE_LEN          = rbs_pkg::PULSE_LEN_DEF,
  parameter int unsigned RING_LEN           = rbs_pkg::RING_LEN_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rbs_pkg::cmd_t                         cmd_i,
  output rbs_pkg::sts_t                         sts_o,
  input  logic                                  cfg_we_i,
  input  logic [rbs_pkg::DELAY_W-1:0]           cfg_wdata_i,
  input  logic                                  data_bit_i,
  input  logic [rbs_pkg::COEF_INDEX_W-1:0]      coef_index_i,
  input  logic signed [rbs_pkg::COEF_W-1:0]     coef_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [rbs_pkg::SAMPLE_W-1:0]   sample_o,
  output logic                                  bit_taken_o
);

  localparam int unsigned RING_AW  = $clog2(RING_LEN);
  localparam int unsigned PULSE_AW = $clog2(PULSE_LEN);
  localparam int unsigned PH_W     = $clog2(SAMPLES_PER_SYMBOL);
  localparam int unsigned CLR_LEN  = (RING_LEN > rbs_pkg::SHIFT_DEPTH) ?
                                     RING_LEN : rbs_pkg::SHIFT_DEPTH;
  localparam int unsigned CLR_W    = $clog2(CLR_LEN);
  localparam int unsigned SPS_MOD  = SAMPLES_PER_SYMBOL % RING_LEN;
  localparam int unsigned SW       = rbs_pkg::SAMPLE_W;
  localparam int unsigned DW       = rbs_pkg::DELAY_W;
  localparam int unsigned SAW      = rbs_pkg::SH_AW;

  logic signed [SW-1:0] ring_mem [RING_LEN];
  logic signed [rbs_pkg::COEF_W-1:0] pulse_mem [PULSE_LEN];
  logic signed [SW-1:0] line_mem [rbs_pkg::SHIFT_DEPTH];

  logic [CLR_W-1:0]    clr_q;
  logic [PH_W-1:0]     phase_q;
  logic                level_q, taken_q;
  logic [RING_AW-1:0]  wp_q, rp_q, acc_idx_q, acc_widx_q;
  logic [PULSE_AW-1:0] acc_cnt_q;
  logic                acc_vld_q;
  logic [SAW-1:0]      sp_q;
  logic [DW-1:0]       delay_q;
  logic signed [SW-1:0] ring_rdata_q, line_rdata_q, s_q;
  logic signed [rbs_pkg::COEF_W-1:0] pulse_rdata_q;
  logic                out_valid_q, out_taken_q;
  logic signed [SW-1:0] out_sample_q;

  logic [RING_AW-1:0]  acc_idx_nx, rp_nx;
  logic [RING_AW:0]    wp_sum;
  logic signed [16:0]  word;
  logic signed [SW:0]  acc_sum;
  logic signed [SW-1:0] acc_sat;
  logic                ring_we;
  logic [RING_AW-1:0]  ring_waddr;
  logic signed [SW-1:0] ring_wdata;
  logic                line_we;
  logic [SAW-1:0]      line_waddr;
  logic signed [SW-1:0] line_wdata;
  logic [DW-1:0]       len;
  logic [SAW-1:0]      sp_eff, sp_inc;
  logic                clr_ring, clr_line, load_ok;

  // pointer arithmetic
  assign acc_idx_nx = (acc_idx_q == RING_AW'(RING_LEN - 1)) ? '0 : acc_idx_q + 1'b1;
  assign rp_nx      = (rp_q == RING_AW'(RING_LEN - 1)) ? '0 : rp_q + 1'b1;
  always_comb begin
    wp_sum = {1'b0, wp_q} + (RING_AW + 1)'(SPS_MOD);
    if (wp_sum >= (RING_AW + 1)'(RING_LEN)) begin
      wp_sum = wp_sum - (RING_AW + 1)'(RING_LEN);
    end
  end

  assign len    = (delay_q > DW'(rbs_pkg::SHIFT_DEPTH)) ? DW'(rbs_pkg::SHIFT_DEPTH) : delay_q;
  assign sp_eff = (sp_q >= len) ? '0 : sp_q;
  assign sp_inc = ((sp_eff + 1'b1) >= len) ? '0 : sp_eff + 1'b1;

  // signed pulse word, saturated accumulate
  assign word    = level_q ? 17'(pulse_rdata_q) : -17'(pulse_rdata_q);
  assign acc_sum = (SW + 1)'(ring_rdata_q) + (SW + 1)'(word);
  assign acc_sat = (acc_sum[SW] != acc_sum[SW-1]) ?
                   (acc_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}}) :
                   acc_sum[SW-1:0];

  assign clr_ring = cmd_i.clr_wr && (clr_q <= CLR_W'(RING_LEN - 1));
  assign clr_line = cmd_i.clr_wr && (clr_q <= CLR_W'(rbs_pkg::SHIFT_DEPTH - 1));
  assign load_ok  = cmd_i.load_wr &&
                    ({1'b0, coef_index_i} < (rbs_pkg::COEF_INDEX_W + 1)'(PULSE_LEN));

  always_comb begin
    ring_we    = 1'b0;
    ring_waddr = rp_q;
    ring_wdata = '0;
    if (clr_ring) begin
      ring_we    = 1'b1;
      ring_waddr = clr_q[RING_AW-1:0];
    end else if (acc_vld_q) begin
      ring_we    = 1'b1;
      ring_waddr = acc_widx_q;
      ring_wdata = acc_sat;
    end else if (cmd_i.ring_clr) begin
      ring_we    = 1'b1;
    end
  end

  always_comb begin
    line_we    = 1'b0;
    line_waddr = sp_eff;
    line_wdata = s_q;
    if (clr_line) begin
      line_we    = 1'b1;
      line_waddr = clr_q[SAW-1:0];
      line_wdata = '0;
    end else if (cmd_i.sh_wr) begin
      line_we    = 1'b1;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    if (cmd_i.acc_issue) begin
      ring_rdata_q <= ring_mem[acc_idx_q];
    end else if (cmd_i.ring_rd) begin
      ring_rdata_q <= ring_mem[rp_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      pulse_mem[coef_index_i[PULSE_AW-1:0]] <= coef_value_i;
    end
    if (cmd_i.acc_issue) begin
      pulse_rdata_q <= pulse_mem[acc_cnt_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_we) begin
      line_mem[line_waddr] <= line_wdata;
    end
    if (cmd_i.sh_rd) begin
      line_rdata_q <= line_mem[sp_q];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_issue) begin
      acc_widx_q <= acc_idx_q;
    end
    if (cmd_i.ring_clr) begin
      s_q <= ring_rdata_q;
    end
    if (cmd_i.out_load) begin
      out_sample_q <= (len == '0) ? s_q : line_rdata_q;
      out_taken_q  <= taken_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      phase_q     <= '0;
      level_q     <= 1'b0;
      taken_q     <= 1'b0;
      wp_q        <= '0;
      rp_q        <= '0;
      acc_idx_q   <= '0;
      acc_cnt_q   <= '0;
      acc_vld_q   <= 1'b0;
      sp_q        <= '0;
      delay_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_vld_q <= cmd_i.acc_issue;
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_we_i) begin
        delay_q <= cfg_wdata_i;
      end
      if (cmd_i.tick_acc) begin
        taken_q   <= (phase_q == '0);
        phase_q   <= (phase_q == PH_W'(SAMPLES_PER_SYMBOL - 1)) ? '0 : phase_q + 1'b1;
        acc_cnt_q <= '0;
        acc_idx_q <= wp_q;
        if (phase_q == '0) begin
          level_q <= level_q ^ data_bit_i;
        end
      end
      if (cmd_i.acc_issue) begin
        acc_cnt_q <= acc_cnt_q + 1'b1;
        acc_idx_q <= acc_idx_nx;
        if (acc_cnt_q == PULSE_AW'(PULSE_LEN - 1)) begin
          wp_q <= wp_sum[RING_AW-1:0];
        end
      end
      if (cmd_i.ring_clr) begin
        rp_q <= rp_nx;
      end
      if (cmd_i.sh_wr) begin
        sp_q <= sp_inc;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last   = (clr_q == CLR_W'(CLR_LEN - 1));
  assign sts_o.phase_zero = (phase_q == '0);
  assign sts_o.acc_last   = (acc_cnt_q == PULSE_AW'(PULSE_LEN - 1));
  assign sts_o.len_zero   = (len == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_sample_q;
  assign bit_taken_o = out_taken_q;

endmodule

// ===== src/rds_biphase_symbol_shaper.sv =====
// ----------------------------------------------------------------------------
// rds_biphase_symbol_shaper
// RDS differential bi-phase symbol shaper for one stream.
// ----------------------------------------------------------------------------
// Slave stream carries one item per transaction: tuser = opcode (tick or
// pulse table load), tdata = data_bit, coef_index, coef_value. A load writes
// one pulse table word if coef_index < PULSE_LEN and gives no result; the
// block stays idle. A tick gives one result on the master stream: tdata =
// sample (signed Q3.15), tuser = bit_taken. The delay line length is written
// through cfg_we_i / cfg_wdata_i; the user must write it only while idle, the
// block itself does not enforce this. A tick reads and clears a ring word,
// with the delay line on writes and reads the delay line, and hands the
// result to the output register; ring and delay line reads are registered.
// A tick that starts a symbol first runs the overlap-add sweep, one pulse
// word per cycle through the ring's read-modify-write port. Reset: counters
// clear, then a clearing pass over max(RING_LEN, 160) addresses zeroes ring
// and delay line; s_axis_tready stays low meanwhile. A stalled receiver
// holds the result in the output register; the next item is still accepted
// and waits at its hand-off until the register frees.
// ----------------------------------------------------------------------------
module rds_biphase_symbol_shaper #(
  parameter int unsigned SAMPLES_PER_SYMBOL = rbs_pkg::SAMPLES_PER_SYMBOL_DEF,
  parameter int unsigned PULSE_LEN          = rbs_pkg::PULSE_LEN_DEF,
  parameter int unsigned RING_LEN           = rbs_pkg::RING_LEN_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rbs_pkg::DELAY_W-1:0]        cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] data_bit, [10:1] coef_index, [26:11] coef_value, [31:27] zero
  input  logic [rbs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] opcode
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [17:0] sample, [23:18] zero
  output logic [rbs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [0] bit_taken
  output logic                               m_axis_tuser
);

  rbs_pkg::cmd_t cmd;
  rbs_pkg::sts_t sts;
  logic signed [rbs_pkg::SAMPLE_W-1:0] sample;

  rbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rbs_datapath #(
    .SAMPLES_PER_SYMBOL (SAMPLES_PER_SYMBOL),
    .PULSE_LEN          (PULSE_LEN),
    .RING_LEN           (RING_LEN)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .data_bit_i   (s_axis_tdata[0]),
    .coef_index_i (s_axis_tdata[10:1]),
    .coef_value_i (s_axis_tdata[26:11]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .sample_o     (sample),
    .bit_taken_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {{(rbs_pkg::OUT_TDATA_W - rbs_pkg::SAMPLE_W){1'b0}}, sample};

endmodule

// ===== src/rbs_checker.sv =====
// ----------------------------------------------------------------------------
// rbs_checker
// Port-level checks on the symbol shaper, bound to the top level.
// ----------------------------------------------------------------------------
module rbs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a tick transaction occupies the block
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == rbs_pkg::OP_TICK) |=>
      !s_axis_tready)
    else $error("ready after tick transaction");

  // a load transaction never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == rbs_pkg::OP_LOAD) &&
      !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result after load transaction");

  // a new result appears only as the block returns to idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result raised while busy");

endmodule

bind rds_biphase_symbol_shaper rbs_checker u_rbs_checker (.*);
